>>> sv/rle_pkg.sv
// ----------------------------------------------------------------------------
// rle_pkg: shared types and constants for the run-length text parser
// Holds the parse phase, result codes, the result record and the push bundle
// that the parse core hands to the result queue.
// ----------------------------------------------------------------------------
package rle_pkg;

    localparam logic [7:0] COLON_CHAR = 8'h3A;

    // Result queue depth; two free slots are needed to take an item.
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_WS,
        PH_START,
        PH_LEN
    } phase_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_START = 3'd1;
    localparam logic [2:0] ST_NO_COLON  = 3'd2;
    localparam logic [2:0] ST_BAD_LEN   = 3'd3;
    localparam logic [2:0] ST_NO_SEP    = 3'd4;
    localparam logic [2:0] ST_UNSORTED  = 3'd5;
    localparam logic [2:0] ST_FG_OVF    = 3'd6;
    localparam logic [2:0] ST_MERGE_OVF = 3'd7;

    localparam logic KIND_PAIR  = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] run_start;
        logic [31:0] run_length;
        logic [63:0] fg_total;
        logic [2:0]  status;
        logic        last;
    } result_t;

    // Results produced by one accepted item: cnt of them, r0 first.
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

>>> sv/rle_core.sv
// ----------------------------------------------------------------------------
// rle_core: character parser and run merger
// Updates the parse state for one character per accepted transfer and
// produces up to two results (a closed pair, then a summary or an error).
// ----------------------------------------------------------------------------
module rle_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           acc_en,
    input  logic [7:0]     ch,
    input  logic           has_char,
    input  logic           eot,
    output rle_pkg::push_t push
);
    import rle_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic        seen_reg, seen_next;
    logic [31:0] cur_reg, cur_next;
    logic [31:0] pstart_reg, pstart_next;
    logic [31:0] plen_reg, plen_next;
    logic        pvalid_reg, pvalid_next;
    logic [32:0] pend_reg, pend_next;
    logic [63:0] fg_reg, fg_next;
    logic        drain_reg, drain_next;

    logic        digit, ws;
    logic [3:0]  dval;
    logic [35:0] acc_dec;
    logic        dec_ovf;

    // after the character
    phase_t      phase_a;
    logic [31:0] acc_a, cur_a;
    logic        seen_a;
    logic        fail_c, acc_c;
    logic [2:0]  code_c;
    // end of text
    logic        fail_e, acc_e;
    logic [2:0]  code_e;
    // run acceptance
    logic        do_acc, unsorted, adjacent, fg_ovf, m_ovf, acc_fail, acc_ok;
    logic [64:0] fg_sum;
    logic [32:0] merge_sum;
    logic [2:0]  acc_code;
    // after acceptance
    logic [31:0] pstart_b, plen_b;
    logic        pvalid_b;
    logic [63:0] fg_b;
    logic [32:0] pend_b;
    logic        fail_any, finish, emit_pair;
    logic [2:0]  fail_code;

    assign digit   = (ch >= 8'h30) && (ch <= 8'h39);
    assign ws      = (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
    assign dval    = digit ? ch[3:0] : 4'd0;
    assign acc_dec = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {32'd0, dval};
    assign dec_ovf = |acc_dec[35:32];

    // character step
    always_comb begin
        phase_a = phase_reg;
        acc_a   = acc_reg;
        seen_a  = seen_reg;
        cur_a   = cur_reg;
        fail_c  = 1'b0;
        code_c  = ST_OK;
        acc_c   = 1'b0;
        if (has_char) begin
            case (phase_reg)
                PH_START: begin
                    if (digit) begin
                        if (dec_ovf) begin
                            fail_c = 1'b1;
                            code_c = ST_BAD_START;
                        end else begin
                            acc_a = acc_dec[31:0];
                        end
                    end else if (ch == COLON_CHAR) begin
                        cur_a   = acc_reg;
                        acc_a   = 32'd0;
                        seen_a  = 1'b0;
                        phase_a = PH_LEN;
                    end else begin
                        fail_c = 1'b1;
                        code_c = ST_NO_COLON;
                    end
                end
                PH_LEN: begin
                    if (digit) begin
                        if (dec_ovf) begin
                            fail_c = 1'b1;
                            code_c = ST_BAD_LEN;
                        end else begin
                            acc_a  = acc_dec[31:0];
                            seen_a = 1'b1;
                        end
                    end else if (!seen_reg || (acc_reg == 32'd0)) begin
                        fail_c = 1'b1;
                        code_c = ST_BAD_LEN;
                    end else if (!ws) begin
                        fail_c = 1'b1;
                        code_c = ST_NO_SEP;
                    end else begin
                        acc_c = 1'b1;
                    end
                end
                default: begin
                    if (digit) begin
                        acc_a   = {28'd0, dval};
                        seen_a  = 1'b1;
                        phase_a = PH_START;
                    end else if (!ws) begin
                        fail_c = 1'b1;
                        code_c = ST_BAD_START;
                    end
                end
            endcase
        end
    end

    // end-of-text step
    always_comb begin
        fail_e = 1'b0;
        code_e = ST_OK;
        acc_e  = 1'b0;
        if (eot && !fail_c && !acc_c) begin
            case (phase_a)
                PH_START: begin
                    fail_e = 1'b1;
                    code_e = ST_NO_COLON;
                end
                PH_LEN: begin
                    if (!seen_a || (acc_a == 32'd0)) begin
                        fail_e = 1'b1;
                        code_e = ST_BAD_LEN;
                    end else begin
                        acc_e = 1'b1;
                    end
                end
                default: begin
                    fail_e = 1'b0;
                end
            endcase
        end
    end

    // run acceptance: order check, total, merge
    assign do_acc    = acc_c || acc_e;
    assign unsorted  = pvalid_reg && ({1'b0, cur_a} < pend_reg);
    assign adjacent  = pvalid_reg && ({1'b0, cur_a} == pend_reg);
    assign fg_sum    = {1'b0, fg_reg} + {33'd0, acc_a};
    assign fg_ovf    = fg_sum[64];
    assign merge_sum = {1'b0, plen_reg} + {1'b0, acc_a};
    assign m_ovf     = merge_sum[32];

    always_comb begin
        if (unsorted) begin
            acc_code = ST_UNSORTED;
        end else if (fg_ovf) begin
            acc_code = ST_FG_OVF;
        end else if (adjacent && m_ovf) begin
            acc_code = ST_MERGE_OVF;
        end else begin
            acc_code = ST_OK;
        end
    end

    assign acc_fail  = do_acc && (acc_code != ST_OK);
    assign acc_ok    = do_acc && (acc_code == ST_OK);
    assign emit_pair = acc_ok && pvalid_reg && !adjacent;
    assign fail_any  = fail_c || fail_e || acc_fail;
    assign fail_code = fail_c ? code_c : (fail_e ? code_e : acc_code);
    assign finish    = eot && !fail_any;

    always_comb begin
        pstart_b = pstart_reg;
        plen_b   = plen_reg;
        pvalid_b = pvalid_reg;
        fg_b     = fg_reg;
        pend_b   = pend_reg;
        if (acc_ok) begin
            fg_b     = fg_sum[63:0];
            pend_b   = {1'b0, cur_a} + {1'b0, acc_a};
            pvalid_b = 1'b1;
            if (adjacent) begin
                plen_b = merge_sum[31:0];
            end else begin
                pstart_b = cur_a;
                plen_b   = acc_a;
            end
        end
    end

    // next state
    always_comb begin
        phase_next  = PH_WS;
        acc_next    = 32'd0;
        seen_next   = 1'b0;
        cur_next    = 32'd0;
        pstart_next = 32'd0;
        plen_next   = 32'd0;
        pvalid_next = 1'b0;
        pend_next   = 33'd0;
        fg_next     = 64'd0;
        drain_next  = 1'b0;
        if (drain_reg) begin
            drain_next = !eot;
        end else if (fail_any) begin
            drain_next = !eot;
        end else if (!finish) begin
            phase_next  = acc_ok ? PH_WS : phase_a;
            acc_next    = acc_ok ? 32'd0 : acc_a;
            seen_next   = acc_ok ? 1'b0 : seen_a;
            cur_next    = cur_a;
            pstart_next = pstart_b;
            plen_next   = plen_b;
            pvalid_next = pvalid_b;
            pend_next   = pend_b;
            fg_next     = fg_b;
        end
    end

    // results
    always_comb begin
        result_t pair_r, final_r;
        pair_r.kind       = KIND_PAIR;
        pair_r.run_start  = pstart_reg;
        pair_r.run_length = plen_reg;
        pair_r.fg_total   = fg_sum[63:0];
        pair_r.status     = ST_OK;
        pair_r.last       = 1'b0;

        final_r.kind = KIND_FINAL;
        final_r.last = 1'b1;
        if (fail_any) begin
            final_r.run_start  = 32'd0;
            final_r.run_length = 32'd0;
            final_r.fg_total   = fg_reg;
            final_r.status     = fail_code;
        end else begin
            final_r.run_start  = pvalid_b ? pstart_b : 32'd0;
            final_r.run_length = pvalid_b ? plen_b : 32'd0;
            final_r.fg_total   = fg_b;
            final_r.status     = ST_OK;
        end

        push.r0 = emit_pair ? pair_r : final_r;
        push.r1 = final_r;
        if (!acc_en || drain_reg) begin
            push.cnt = 2'd0;
        end else begin
            push.cnt = {1'b0, emit_pair} + {1'b0, fail_any || finish};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_WS;
            acc_reg    <= 32'd0;
            seen_reg   <= 1'b0;
            cur_reg    <= 32'd0;
            pstart_reg <= 32'd0;
            plen_reg   <= 32'd0;
            pvalid_reg <= 1'b0;
            pend_reg   <= 33'd0;
            fg_reg     <= 64'd0;
            drain_reg  <= 1'b0;
        end else if (acc_en) begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            seen_reg   <= seen_next;
            cur_reg    <= cur_next;
            pstart_reg <= pstart_next;
            plen_reg   <= plen_next;
            pvalid_reg <= pvalid_next;
            pend_reg   <= pend_next;
            fg_reg     <= fg_next;
            drain_reg  <= drain_next;
        end
    end

endmodule

>>> sv/rle_res_fifo.sv
// ----------------------------------------------------------------------------
// rle_res_fifo: result queue
// Takes up to two results per cycle and presents one per cycle to the
// result channel while it is ready; signals room while two entries are free.
// ----------------------------------------------------------------------------
module rle_res_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  rle_pkg::push_t   push,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output rle_pkg::result_t out_res
);
    import rle_pkg::*;

    result_t                ent_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0]   wr_reg, wr_next;
    logic [RES_PTR_W-1:0]   rd_reg, rd_next;
    logic [RES_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   pop;
    logic [RES_PTR_W-1:0]   wr_plus1;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != '0);
    assign out_res   = ent_reg[rd_reg];
    assign room      = (cnt_reg <= RES_CNT_W'(RES_DEPTH - 2));
    assign wr_plus1  = wr_reg + 1'b1;

    always_comb begin
        wr_next  = wr_reg + RES_PTR_W'(push.cnt);
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + RES_CNT_W'(push.cnt) - RES_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            ent_reg[wr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2) begin
            ent_reg[wr_plus1] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> sv/rle_run_text_parser.sv
// Each result is registered in the result queue and offered on m_ after older results.
// Throughput: one character per cycle while s_tready is high; a character closing a pair
//   and ending the text yields two results, sent on one per cycle while m_tready is high.
// s_tready is high while the four-entry result queue has two free entries.
// Reset: synchronous, active-low aresetn clears the parse state and empties the queue;
//   no clearing pass is needed, the block takes input the first cycle after reset.
// ----------------------------------------------------------------------------
// rle_run_text_parser: mask run-length text parser
// Parses whitespace-separated start:length decimal pairs one character per
// transfer, merges adjacent runs, and emits closed runs, a closing summary
// with the foreground total, or one error result per string.
// ----------------------------------------------------------------------------
module rle_run_text_parser (
    input  logic         aclk,
    input  logic         aresetn,
    // character channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] ch
    input  logic         s_tuser,   // [0] has_char
    input  logic         s_tlast,   // end_of_text
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // [31:0] run_start, [63:32] run_length,
                                    // [127:64] foreground_total, [130:128] status, rest zero
    output logic         m_tuser,   // [0] item_kind
    output logic         m_tlast    // last
);
    import rle_pkg::*;

    logic    acc_en;
    push_t   push;
    result_t out_res;

    // A character transfer completes when both sides agree.
    assign acc_en = s_tvalid && s_tready;

    // Parse state and run merging; produces the results for this transfer.
    rle_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .acc_en   (acc_en),
        .ch       (s_tdata),
        .has_char (s_tuser),
        .eot      (s_tlast),
        .push     (push)
    );

    // Hold results until the result channel takes them; ready comes from
    // the registered fill count only, so no path runs from m_tready to s_tready.
    rle_res_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the result onto the stream bus.
    assign m_tdata = {5'd0, out_res.status, out_res.fg_total,
                      out_res.run_length, out_res.run_start};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

    // Results only appear for an accepted character transfer.
    a_push_needs_xfer : assert property (@(posedge aclk) disable iff (!aresetn)
        (push.cnt != 2'd0) |-> acc_en)
        else $error("results pushed without a character transfer");

    // Two results are always a closed pair followed by the final result.
    a_two_results_order : assert property (@(posedge aclk) disable iff (!aresetn)
        (push.cnt == 2'd2) |-> (push.r0.kind == KIND_PAIR) && !push.r0.last
                               && (push.r1.kind == KIND_FINAL) && push.r1.last)
        else $error("two results not in pair-then-final order");

    // A pair result is never marked as the end of the string.
    a_pair_not_last : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_PAIR)) |-> !m_tlast && (m_tdata[130:128] == ST_OK))
        else $error("pair result carries last or an error code");

    // An error result carries no run.
    a_error_no_run : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[130:128] != ST_OK)) |-> (m_tdata[63:0] == 64'd0) && m_tlast)
        else $error("error result carries a run");

endmodule

>>> bench/rle_run_text_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_run_text_parser_tb: self-checking bench for the run-length text parser
// Feeds mask run-length text one character per transfer, mirrors the parse in
// a local predictor, and compares every result transfer field by field with
// the oldest predicted result. Covers directed corner cases, long receiver
// hold-off, sender pauses, back-to-back traffic and randomized texts.
// ----------------------------------------------------------------------------
module rle_run_text_parser_tb;
    import rle_pkg::*;

    localparam int              CYCLE_LIMIT  = 600000;
    localparam int              HOLD_CYCLES  = 80;
    localparam int              TAIL_CYCLES  = 10;
    localparam int              RANDOM_ITEMS = 770;
    localparam int              MAX_REPORTS  = 10;
    localparam longint unsigned U32_MAX      = 64'hFFFF_FFFF;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    // Handshake between the test sequence and the result sink.
    bit rst_done = 1'b0;
    bit hold_req = 1'b0;   // request one long stretch of m_tready low
    bit no_idle  = 1'b0;   // suppress random gaps on both sides

    int items_sent   = 0;
    int mismatch_cnt = 0;
    int cycle_cnt    = 0;

    // Predicted results, oldest first.
    result_t run_results_due[$];

    // Mirror of the parse state.
    phase_t      ps_phase;
    logic [31:0] ps_acc;
    logic        ps_digit;
    logic [31:0] ps_start;
    logic [31:0] ps_open_start;
    logic [31:0] ps_open_len;
    logic        ps_open;
    logic [32:0] ps_end;
    logic [63:0] ps_fg;
    logic        ps_skip;

    rle_run_text_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop if the run hangs anywhere.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void reset_parse();
        ps_phase      = PH_WS;
        ps_acc        = '0;
        ps_digit      = 1'b0;
        ps_start      = '0;
        ps_open_start = '0;
        ps_open_len   = '0;
        ps_open       = 1'b0;
        ps_end        = '0;
        ps_fg         = '0;
        ps_skip       = 1'b0;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic void post_result(logic kind, logic [31:0] start, logic [31:0] len,
                                        logic [2:0] status, logic last);
        result_t r;
        r.kind       = kind;
        r.run_start  = start;
        r.run_length = len;
        r.fg_total   = ps_fg;
        r.status     = status;
        r.last       = last;
        run_results_due = {run_results_due, r};
    endfunction

    // One error result; drop the rest of the string unless it ends here.
    function automatic void parse_error(logic [2:0] code, logic eot);
        post_result(KIND_FINAL, 32'd0, 32'd0, code, 1'b1);
        reset_parse();
        ps_skip = !eot;
    endfunction

    // Closing summary carries the open run, if any.
    function automatic void close_string();
        if (ps_open)
            post_result(KIND_FINAL, ps_open_start, ps_open_len, ST_OK, 1'b1);
        else
            post_result(KIND_FINAL, 32'd0, 32'd0, ST_OK, 1'b1);
        reset_parse();
    endfunction

    // Take the run ps_start:ps_acc; merge it or close the open run as a pair.
    function automatic logic [2:0] commit_run();
        logic [32:0] run_start33;
        logic [32:0] merged;
        run_start33 = {1'b0, ps_start};
        if (ps_open && run_start33 < ps_end)
            return ST_UNSORTED;
        if ({32'd0, ps_acc} > ~ps_fg)
            return ST_FG_OVF;
        if (ps_open && run_start33 == ps_end) begin
            merged = {1'b0, ps_open_len} + {1'b0, ps_acc};
            if (merged[32])
                return ST_MERGE_OVF;
            ps_open_len = merged[31:0];
            ps_fg       = ps_fg + {32'd0, ps_acc};
        end else begin
            ps_fg = ps_fg + {32'd0, ps_acc};
            if (ps_open)
                post_result(KIND_PAIR, ps_open_start, ps_open_len, ST_OK, 1'b0);
            ps_open_start = ps_start;
            ps_open_len   = ps_acc;
            ps_open       = 1'b1;
        end
        ps_end = run_start33 + {1'b0, ps_acc};
        return ST_OK;
    endfunction

    function automatic void parse_char(logic [7:0] c, logic has, logic eot);
        logic        dig;
        logic [35:0] nxt;
        logic [2:0]  code;
        if (ps_skip) begin
            if (eot)
                reset_parse();
            return;
        end
        if (has) begin
            dig = (c >= 8'h30) && (c <= 8'h39);
            nxt = {4'd0, ps_acc} * 36'd10 + (dig ? {32'd0, c[3:0]} : 36'd0);
            case (ps_phase)
                PH_START: begin
                    if (dig) begin
                        if (nxt[35:32] != 4'd0) begin
                            parse_error(ST_BAD_START, eot);
                            return;
                        end
                        ps_acc = nxt[31:0];
                    end else if (c == COLON_CHAR) begin
                        ps_start = ps_acc;
                        ps_acc   = '0;
                        ps_digit = 1'b0;
                        ps_phase = PH_LEN;
                    end else begin
                        parse_error(ST_NO_COLON, eot);
                        return;
                    end
                end
                PH_LEN: begin
                    if (dig) begin
                        if (nxt[35:32] != 4'd0) begin
                            parse_error(ST_BAD_LEN, eot);
                            return;
                        end
                        ps_acc   = nxt[31:0];
                        ps_digit = 1'b1;
                    end else if (!ps_digit || ps_acc == 32'd0) begin
                        parse_error(ST_BAD_LEN, eot);
                        return;
                    end else if (!is_blank(c)) begin
                        parse_error(ST_NO_SEP, eot);
                        return;
                    end else begin
                        code = commit_run();
                        if (code != ST_OK) begin
                            parse_error(code, eot);
                            return;
                        end
                        ps_phase = PH_WS;
                        ps_acc   = '0;
                        ps_digit = 1'b0;
                    end
                end
                default: begin
                    if (dig) begin
                        ps_acc   = {28'd0, c[3:0]};
                        ps_digit = 1'b1;
                        ps_phase = PH_START;
                    end else if (!is_blank(c)) begin
                        parse_error(ST_BAD_START, eot);
                        return;
                    end
                end
            endcase
        end
        if (eot) begin
            if (ps_phase == PH_START) begin
                parse_error(ST_NO_COLON, eot);
            end else if (ps_phase == PH_LEN) begin
                // End inside a length acts as a trailing separator.
                if (!ps_digit || ps_acc == 32'd0) begin
                    parse_error(ST_BAD_LEN, eot);
                end else begin
                    code = commit_run();
                    if (code != ST_OK)
                        parse_error(code, eot);
                    else
                        close_string();
                end
            end else begin
                close_string();
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void log_mismatch(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    function automatic void check_result();
        result_t want;
        if (run_results_due.size() == 0) begin
            log_mismatch($sformatf(
                "unexpected result: kind %0b start %0d len %0d total %0d status %0d last %0b",
                m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[127:64],
                m_tdata[130:128], m_tlast));
            return;
        end
        want = run_results_due.pop_front();
        if (m_tuser !== want.kind || m_tdata[31:0] !== want.run_start ||
            m_tdata[63:32] !== want.run_length || m_tdata[127:64] !== want.fg_total ||
            m_tdata[130:128] !== want.status || m_tdata[135:131] !== 5'd0 ||
            m_tlast !== want.last)
            log_mismatch($sformatf({"result mismatch: expected kind %0b start %0d len %0d ",
                "total %0d status %0d last %0b; got kind %0b start %0d len %0d total %0d ",
                "status %0d last %0b pad %0h"},
                want.kind, want.run_start, want.run_length, want.fg_total, want.status,
                want.last, m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[127:64],
                m_tdata[130:128], m_tlast, m_tdata[135:131]));
    endfunction

    // Outputs and m_tready only move at rising edges, so the falling edge
    // sees exactly what the next rising edge will transfer.
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_result();
    end

    // ------------------------------------------------------------------
    // Idle gaps and result sink
    // ------------------------------------------------------------------

    // Mostly zero, often short, now and then long.
    function automatic int idle_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial begin : result_sink
        int n;
        m_tready <= 1'b0;
        wait (rst_done);
        forever begin
            if (hold_req) begin
                // Hold off long enough for the result queue to fill and
                // stall the character channel.
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                n = idle_len();
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Character driver
    // ------------------------------------------------------------------

    // Enter and leave on a rising edge; s_tvalid stays high on exit so the
    // next item can follow without a bubble.
    task automatic send_item(logic [7:0] c, logic has, logic eot);
        int   gap;
        logic took;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= has;
        s_tlast  <= eot;
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        parse_char(c, has, eot);
        if (has || eot)
            items_sent++;
    endtask

    // Send one string; close it on its last character or with an empty
    // end-marker transfer. Noise adds ignored transfers with has_char low.
    task automatic send_text(byte unsigned txt[$], bit eot_last, bit noise);
        int i;
        for (i = 0; i < txt.size(); i++) begin
            if (noise && $urandom_range(0, 24) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(txt[i], 1'b1, eot_last && (i == txt.size() - 1));
        end
        if (!eot_last || txt.size() == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic send_str(string s, bit eot_last);
        byte unsigned txt[$];
        int           i;
        for (i = 0; i < s.len(); i++)
            txt = {txt, s[i]};
        send_text(txt, eot_last, 1'b0);
    endtask

    // Drop valid and hold until every predicted result has been taken.
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (run_results_due.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Text generation
    // ------------------------------------------------------------------

    function automatic void add_num(ref byte unsigned txt[$], input longint unsigned v);
        string s;
        int    i;
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 9) == 0)
            s = {"0", s};
        for (i = 0; i < s.len(); i++)
            txt = {txt, s[i]};
    endfunction

    function automatic void add_blank(ref byte unsigned txt[$], input int n);
        int i;
        int r;
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            if (r < 5)
                txt = {txt, 8'h20};
            else
                txt = {txt, 8'(r + 4)};
        end
    endfunction

    function automatic void add_run(ref byte unsigned txt[$], input longint unsigned s,
                                    input longint unsigned l);
        add_num(txt, s);
        txt = {txt, COLON_CHAR};
        add_num(txt, l);
    endfunction

    function automatic longint unsigned pick_len();
        int          r;
        int unsigned x;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 64'($urandom_range(1, 20));
        if (r < 88)
            return 64'($urandom_range(1, 5000));
        if (r < 97) begin
            x = $urandom();
            return (x == 0) ? 64'd1 : 64'(x);
        end
        return U32_MAX;
    endfunction

    // Sorted runs with random spacing, adjacency and blanks; a quarter of
    // the texts then get one defect.
    function automatic void gen_text(ref byte unsigned txt[$]);
        longint unsigned pos;
        longint unsigned run_s;
        longint unsigned l1;
        int              n_runs;
        int              i;
        int              r;
        int              n;
        txt.delete();
        r = $urandom_range(0, 9);
        if (r < 8)
            pos = 64'($urandom_range(0, 50));
        else if (r == 8)
            pos = 64'($urandom());
        else
            pos = $urandom_range(0, 1) ? U32_MAX : U32_MAX - 64'($urandom_range(1, 300));
        if ($urandom_range(0, 2) == 0)
            add_blank(txt, $urandom_range(1, 2));
        n_runs = $urandom_range(0, 4);
        for (i = 0; i < n_runs; i++) begin
            if (i > 0) begin
                add_blank(txt, $urandom_range(1, 3));
                if ($urandom_range(0, 2) != 0)
                    pos = pos + 64'($urandom_range(1, 40));
            end
            if (pos > U32_MAX)
                break;
            run_s = pick_len();
            add_run(txt, pos, run_s);
            pos = pos + run_s;
        end
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 6))
                0: begin
                    // overwrite one character with any byte
                    if (txt.size() > 0)
                        txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
                end
                1: begin
                    // cut the text short
                    if (txt.size() > 1) begin
                        n = $urandom_range(1, txt.size() - 1);
                        while (txt.size() > n)
                            void'(txt.pop_back());
                    end
                end
                2: begin
                    // start too large for 32 bits
                    add_blank(txt, 1);
                    add_num(txt, $urandom_range(0, 1)
                                 ? 64'd4294967296 + 64'($urandom_range(0, 999))
                                 : 64'd99999999999);
                    txt = {txt, COLON_CHAR};
                    txt = {txt, 8'h31};
                end
                3: begin
                    // length too large for 32 bits
                    add_blank(txt, 1);
                    add_num(txt, pos);
                    txt = {txt, COLON_CHAR};
                    add_num(txt, 64'd4294967296 + 64'($urandom_range(0, 9999)));
                end
                4: begin
                    // run that starts inside the previous one
                    add_blank(txt, 1);
                    if (pos == 0) begin
                        add_run(txt, 64'd0, 64'd2);
                        add_blank(txt, 1);
                        pos = 2;
                    end
                    run_s = pos - 1;
                    if (run_s > U32_MAX)
                        run_s = U32_MAX;
                    add_run(txt, run_s, 64'($urandom_range(1, 9)));
                end
                5: begin
                    // two adjacent runs whose merged length overflows
                    add_blank(txt, 1);
                    run_s = pos + 64'($urandom_range(1, 9));
                    l1    = 64'h8000_0000 + 64'($urandom_range(0, 32'h3FFF_FFFF));
                    add_run(txt, run_s, l1);
                    add_blank(txt, 1);
                    add_run(txt, run_s + l1,
                            64'h1_0000_0000 - l1 + 64'($urandom_range(0, 999)));
                end
                default: begin
                    // punctuation where a separator belongs, then more text
                    add_blank(txt, 1);
                    add_run(txt, pos, 64'($urandom_range(1, 9)));
                    txt = {txt, 8'($urandom_range(8'h21, 8'h2F))};
                    add_run(txt, pos + 64'd20, 64'd1);
                end
            endcase
        end
        if ($urandom_range(0, 2) == 0)
            add_blank(txt, $urandom_range(1, 2));
    endfunction

    task automatic send_random_text(bit noise);
        byte unsigned txt[$];
        gen_text(txt);
        send_text(txt, (txt.size() > 0) && ($urandom_range(0, 1) == 1), noise);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_cases();
        // Empty string closed by a bare end marker: zero summary.
        send_item(8'h00, 1'b0, 1'b1);
        // Merge 0:1 with 1:2, then 9:1 closes the pair on the same transfer
        // that ends the text, giving two results at once.
        send_str("0:1 1:2\t9:1", 1'b1);
        // End inside an empty length, end inside a start.
        send_str("7:", 1'b1);
        send_str("12", 1'b1);
        // Missing colon mid-string; the tail is dropped up to the end marker.
        send_str("3x9:", 1'b0);
        // Bad start on the very transfer that ends the text.
        send_item(8'hFF, 1'b1, 1'b1);
        // Zero length, then a missing separator, then an overlap.
        send_str("5:0 ", 1'b1);
        send_str("5:3;", 1'b0);
        send_str("9:2 10:1", 1'b0);
        // Odd blanks and an ignored transfer in the middle of a run.
        send_str({"\013\014\015", "4"}, 1'b0);
        send_item(8'h36, 1'b1, 1'b0);
        send_item(COLON_CHAR, 1'b0, 1'b0);
        send_item(COLON_CHAR, 1'b1, 1'b0);
        send_item(8'h31, 1'b1, 1'b1);
    endtask

    // Receiver holds off while the sender streams short disjoint runs, each one after
    // the first closing a pair, so the block fills up and stalls its input.
    task automatic test_result_backpressure();
        byte unsigned txt[$];
        int           i;
        for (i = 0; i < 16; i++) begin
            add_run(txt, 64'(2 * i), 64'd1);
            txt = {txt, 8'h20};
        end
        hold_req = 1'b1;
        send_text(txt, 1'b1, 1'b0);
    endtask

    // Sender waits for every result before the next string.
    task automatic test_sender_pause();
        int i;
        for (i = 0; i < 4; i++) begin
            send_random_text(1'b0);
            pause_until_drained();
        end
    endtask

    // No gaps on either side for a stretch.
    task automatic test_back_to_back();
        int goal;
        goal    = items_sent + 80;
        no_idle = 1'b1;
        while (items_sent < goal)
            send_random_text(1'b0);
        no_idle = 1'b0;
    endtask

    task automatic test_random_texts();
        int goal;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
            send_random_text(1'b1);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin : main_seq
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= 1'b0;
        s_tlast  <= 1'b0;
        aresetn  <= 1'b0;
        reset_parse();
        repeat (6) @(posedge aclk);
        aresetn  <= 1'b1;
        rst_done = 1'b1;

        test_directed_cases();
        test_result_backpressure();
        test_sender_pause();
        test_back_to_back();
        test_random_texts();

        // Drain, then keep watching for any extra result before reporting.
        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
